// ===== src/h2c_pkg.sv =====
`default_nettype none

package h2c_pkg;

  localparam int HEIGHT_FRAC_BITS_DEF = 8;
  localparam int FACTOR_BITS_DEF      = 16;
  localparam int QUEUE_DEPTH          = 4;
  localparam int QUEUE_PTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_COUNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_INDEX_BITS       = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_INV_SCALE_WET    = 3'd0,
    REG_INV_SCALE_DRY    = 3'd1,
    REG_DRY_DARK_COLOR   = 3'd2,
    REG_DRY_LIGHT_COLOR  = 3'd3,
    REG_SHORE_COLOR      = 3'd4,
    REG_HIGH_WATER_COLOR = 3'd5,
    REG_DEEP_WATER_COLOR = 3'd6
  } reg_index_t;

  localparam logic [23:0] INV_SCALE_WET_RST    = 24'd838861;
  localparam logic [23:0] INV_SCALE_DRY_RST    = 24'd5592;
  localparam logic [23:0] DRY_DARK_COLOR_RST   = 24'd2310662;
  localparam logic [23:0] DRY_LIGHT_COLOR_RST  = 24'd12053168;
  localparam logic [23:0] SHORE_COLOR_RST      = 24'd15525589;
  localparam logic [23:0] HIGH_WATER_COLOR_RST = 24'd9175836;
  localparam logic [23:0] DEEP_WATER_COLOR_RST = 24'd207708;

  typedef struct packed {
    logic signed [23:0] water_depth;
    logic signed [23:0] bed_height;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic [23:0] inv_scale_wet;
    logic [23:0] inv_scale_dry;
    logic [23:0] dry_dark_color;
    logic [23:0] dry_light_color;
    logic [23:0] shore_color;
    logic [23:0] high_water_color;
    logic [23:0] deep_water_color;
  } cfg_t;

  // One classified word: magnitude to scale, its reciprocal scale and the two end colours.
  typedef struct packed {
    logic [24:0] mag;
    logic [23:0] inv;
    logic        force_one;
    logic [23:0] c1;
    logic [23:0] c2;
  } class_t;

  typedef struct packed {
    logic                        full;
    logic                        empty;
    logic [QUEUE_COUNT_BITS-1:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== src/h2c_regs.sv =====
`default_nettype none

module h2c_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [h2c_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [23:0]                       cfg_data,
  output h2c_pkg::cfg_t                          cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_scale_wet    <= h2c_pkg::INV_SCALE_WET_RST;
      cfg.inv_scale_dry    <= h2c_pkg::INV_SCALE_DRY_RST;
      cfg.dry_dark_color   <= h2c_pkg::DRY_DARK_COLOR_RST;
      cfg.dry_light_color  <= h2c_pkg::DRY_LIGHT_COLOR_RST;
      cfg.shore_color      <= h2c_pkg::SHORE_COLOR_RST;
      cfg.high_water_color <= h2c_pkg::HIGH_WATER_COLOR_RST;
      cfg.deep_water_color <= h2c_pkg::DEEP_WATER_COLOR_RST;
    end else if (cfg_valid) begin
      unique case (h2c_pkg::reg_index_t'(cfg_index))
        h2c_pkg::REG_INV_SCALE_WET:    cfg.inv_scale_wet    <= cfg_data;
        h2c_pkg::REG_INV_SCALE_DRY:    cfg.inv_scale_dry    <= cfg_data;
        h2c_pkg::REG_DRY_DARK_COLOR:   cfg.dry_dark_color   <= cfg_data;
        h2c_pkg::REG_DRY_LIGHT_COLOR:  cfg.dry_light_color  <= cfg_data;
        h2c_pkg::REG_SHORE_COLOR:      cfg.shore_color      <= cfg_data;
        h2c_pkg::REG_HIGH_WATER_COLOR: cfg.high_water_color <= cfg_data;
        h2c_pkg::REG_DEEP_WATER_COLOR: cfg.deep_water_color <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/h2c_front.sv =====
`default_nettype none

module h2c_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire h2c_pkg::cfg_t  cfg,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire h2c_pkg::item_t item,
  output logic                push,
  output h2c_pkg::class_t     push_data,
  input  wire logic           q_full
);

  logic            held;
  h2c_pkg::class_t cls;
  logic            wet;
  logic signed [24:0] surface;
  logic        [24:0] bed_ext;

  assign push       = held && !q_full;
  assign item_ready = !held || !q_full;

  assign wet     = item.water_depth > 24'sd0;
  assign surface = 25'(item.water_depth) + 25'(item.bed_height);
  assign bed_ext = {1'b0, item.bed_height};

  always_comb begin
    if (wet) begin
      cls.mag       = surface[24] ? 25'(-surface) : 25'(surface);
      cls.inv       = cfg.inv_scale_wet;
      cls.force_one = 1'b0;
      cls.c1        = cfg.shore_color;
      cls.c2        = (surface > 25'sd0) ? cfg.high_water_color : cfg.deep_water_color;
    end else begin
      cls.mag       = item.bed_height[23] ? 25'd0 : bed_ext;
      cls.inv       = cfg.inv_scale_dry;
      cls.force_one = item.bed_height[23];
      cls.c1        = cfg.dry_dark_color;
      cls.c2        = cfg.dry_light_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_ready) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      push_data <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== src/h2c_queue.sv =====
`default_nettype none

module h2c_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire h2c_pkg::class_t push_data,
  input  wire logic            pop,
  output h2c_pkg::class_t      pop_data,
  output h2c_pkg::q_stat_t     stat
);

  localparam int D  = h2c_pkg::QUEUE_DEPTH;
  localparam int PB = h2c_pkg::QUEUE_PTR_BITS;
  localparam int CB = h2c_pkg::QUEUE_COUNT_BITS;

  h2c_pkg::class_t entries [D];
  logic [PB-1:0]   wr_ptr;
  logic [PB-1:0]   rd_ptr;
  logic [CB-1:0]   count;

  assign stat.count = count;
  assign stat.full  = count == CB'(D);
  assign stat.empty = count == '0;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(D - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(D - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CB'(push) - CB'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/h2c_back.sv =====
`default_nettype none

module h2c_back #(
  parameter int HEIGHT_FRAC_BITS = h2c_pkg::HEIGHT_FRAC_BITS_DEF,
  parameter int FACTOR_BITS      = h2c_pkg::FACTOR_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire h2c_pkg::class_t pop_data,
  input  wire logic            q_empty,
  output logic                 pop,
  output logic                 back_en,
  output logic                 color_valid,
  input  wire logic            color_ready,
  output h2c_pkg::color_t      color
);

  localparam int FB    = FACTOR_BITS;
  localparam int UW    = FB + 1;
  localparam int PW    = 49;
  localparam int SH    = HEIGHT_FRAC_BITS + 24 - FB;
  localparam int SH_M1 = (SH > 0) ? SH - 1 : 0;
  localparam int AW    = FB + 12;

  localparam logic [UW-1:0] ONE    = {1'b1, {FB{1'b0}}};
  localparam logic [PW:0]   RND_S  = (SH > 0) ? ((PW + 1)'(1) << SH_M1) : '0;
  localparam logic [2*UW:0] RND_F  = (2 * UW + 1)'(1) << (FB - 1);
  localparam logic [AW-1:0] HALF_A = AW'(1) << (FB - 1);

  logic [7:1] v;
  logic       en;

  logic [PW-1:0]   prod1;
  logic            force1;
  logic [23:0]     c1_s [1:6];
  logic [23:0]     c2_s [1:6];
  logic [UW-1:0]   u2, u3, u4;
  logic [2*UW-1:0] uu3;
  logic [UW-1:0]   sq4;
  logic [2*UW-1:0] su5;
  logic [UW-1:0]   f6;

  logic [PW:0]     s_sum;
  logic [PW:0]     s_full;
  logic [UW-1:0]   u_calc;
  logic [2*UW:0]   sq_sum;
  logic [2*UW:0]   f_sum;
  logic [7:0]      mix_res [3];

  assign en          = !v[7] || color_ready;
  assign back_en     = en;
  assign pop         = en && !q_empty;
  assign color_valid = v[7];

  assign s_sum  = (PW + 1)'(prod1) + RND_S;
  assign s_full = s_sum >> SH;

  always_comb begin
    if (force1) begin
      u_calc = ONE;
    end else if (s_full > (PW + 1)'(ONE)) begin
      u_calc = '0;
    end else begin
      u_calc = ONE - UW'(s_full);
    end
  end

  assign sq_sum = (2 * UW + 1)'(uu3) + RND_F;
  assign f_sum  = (2 * UW + 1)'(su5) + RND_F;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int POS = 16 - 8 * k;
    logic [7:0]          a;
    logic [7:0]          b;
    logic signed [8:0]   diff;
    logic signed [UW:0]  fs;
    logic signed [UW+9:0] mprod;
    logic signed [AW-1:0] acc;

    assign a     = c1_s[6][POS +: 8];
    assign b     = c2_s[6][POS +: 8];
    assign diff  = $signed({1'b0, a}) - $signed({1'b0, b});
    assign fs    = $signed({1'b0, f6});
    assign mprod = fs * diff;
    assign acc   = $signed({{(AW - FB - 8){1'b0}}, b, {FB{1'b0}}}) + AW'(mprod)
                   + $signed(HALF_A);
    assign mix_res[k] = acc[FB +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:1], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1   <= PW'(pop_data.mag * pop_data.inv);
      force1  <= pop_data.force_one;
      c1_s[1] <= pop_data.c1;
      c2_s[1] <= pop_data.c2;
      for (int i = 2; i <= 6; i++) begin
        c1_s[i] <= c1_s[i-1];
        c2_s[i] <= c2_s[i-1];
      end
      u2          <= u_calc;
      uu3         <= u2 * u2;
      u3          <= u2;
      sq4         <= UW'(sq_sum >> FB);
      u4          <= u3;
      su5         <= sq4 * u4;
      f6          <= UW'(f_sum >> FB);
      color.red   <= mix_res[0];
      color.green <= mix_res[1];
      color.blue  <= mix_res[2];
    end
  end

endmodule

`default_nettype wire

// ===== src/height_to_color_map.sv =====
// Colours one grid point of a shallow-water height field per word.
// Item channel: item_valid/item_ready with item (water depth, bed height,
// signed fixed point). Colour channel: color_valid/color_ready with color
// (red, green, blue, 8 bits each). Configuration channel: cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high and indexes past the
// last register are ignored. Writes are meant to happen while the block is idle.
// A classifying front stage picks the region, magnitude and end colours and
// places the word in a four-entry queue; a seven-stage back pipeline scales,
// cubes and mixes it. Throughput is one word per cycle, set by the back
// pipeline advancing once per cycle when the colour output is free or being
// taken. When the receiver stalls, the back pipeline holds, the queue fills,
// and item_ready falls once the queue and front stage are full.
// Reset empties the front stage, queue and pipeline and returns all
// registers to their default colours and scales.
`default_nettype none

module height_to_color_map #(
  parameter int HEIGHT_FRAC_BITS = h2c_pkg::HEIGHT_FRAC_BITS_DEF,
  parameter int FACTOR_BITS      = h2c_pkg::FACTOR_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_ready,
  input  wire h2c_pkg::item_t                     item,
  output logic                                    color_valid,
  input  wire logic                               color_ready,
  output h2c_pkg::color_t                         color,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [h2c_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [23:0]                        cfg_data
);

  h2c_pkg::cfg_t    cfg;
  h2c_pkg::class_t  push_data;
  h2c_pkg::class_t  pop_data;
  h2c_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;
  logic             back_en;

  h2c_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  h2c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_stat.full)
  );

  h2c_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  h2c_back #(
    .HEIGHT_FRAC_BITS (HEIGHT_FRAC_BITS),
    .FACTOR_BITS      (FACTOR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_data    (pop_data),
    .q_empty     (q_stat.empty),
    .pop         (pop),
    .back_en     (back_en),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .color       (color)
  );

  a_reset_empty : assert property (@(posedge clk) rst |=> !color_valid)
    else $error("colour output valid straight after reset");

  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= h2c_pkg::QUEUE_COUNT_BITS'(h2c_pkg::QUEUE_DEPTH))
    else $error("queue count beyond its depth");

  a_pop_stall : assert property (@(posedge clk) disable iff (rst)
    (color_valid && !color_ready) |-> !pop)
    else $error("queue popped while the colour output is stalled");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    pop |-> (!q_stat.empty && back_en))
    else $error("queue popped when empty or with the pipeline held");

endmodule

`default_nettype wire
